@@ src/sca_pkg.sv @@
// ----------------------------------------------------------------------------
// sca_pkg
// shared types and operation codes of the scalar constant alu
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 5;

  // operation codes, 25..31 are unsupported
  typedef enum logic [KindW-1:0] {
    OP_ADD        = 5'd0,
    OP_ADDC       = 5'd1,
    OP_ADD_CO     = 5'd2,
    OP_SUB        = 5'd3,
    OP_SUBB       = 5'd4,
    OP_SUB_BO     = 5'd5,
    OP_MUL_LO     = 5'd6,
    OP_AND        = 5'd7,
    OP_ANDN       = 5'd8,
    OP_OR         = 5'd9,
    OP_ORN        = 5'd10,
    OP_XOR        = 5'd11,
    OP_NOT        = 5'd12,
    OP_SHL        = 5'd13,
    OP_LSR        = 5'd14,
    OP_ASR        = 5'd15,
    OP_MASK32     = 5'd16,
    OP_MASK64_LO  = 5'd17,
    OP_MASK64_HI  = 5'd18,
    OP_ADD3       = 5'd19,
    OP_SHL_ADD    = 5'd20,
    OP_SHL_ADD_CO = 5'd21,
    OP_ADD_SHL    = 5'd22,
    OP_XOR_ADD    = 5'd23,
    OP_SHL_OR     = 5'd24
  } sca_op_t;

  // one operation with its operands
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [WordW-1:0] arg_a;
    logic [WordW-1:0] arg_b;
    logic [WordW-1:0] arg_c;
  } sca_item_t;

  // one result
  typedef struct packed {
    logic [WordW-1:0] value;
    logic             unsupported;
  } sca_result_t;

endpackage

`default_nettype wire

@@ src/sca_alu.sv @@
// ----------------------------------------------------------------------------
// sca_alu
// combinational datapath, one operation per item
// ----------------------------------------------------------------------------
`default_nettype none

module sca_alu (
  input  sca_pkg::sca_item_t   item,
  output sca_pkg::sca_result_t res
);

  logic [4:0]  sh;
  logic        ci;
  logic [32:0] sum_ci;
  logic [31:0] shl;
  logic [31:0] prod;
  logic [31:0] mask32;
  logic [63:0] mask64;
  logic [63:0] wide;
  logic [32:0] low_sum;
  logic [31:0] wide_hi;
  logic        borrow;

  always_comb begin
    sh      = item.arg_b[4:0];
    ci      = item.arg_c[0];
    sum_ci  = {1'b0, item.arg_a} + {1'b0, item.arg_b} + {32'd0, ci};
    shl     = item.arg_a << sh;
    prod    = item.arg_a * item.arg_b;
    mask32  = ((32'd1 << item.arg_a[4:0]) - 32'd1) << sh;
    mask64  = ((64'd1 << item.arg_a[5:0]) - 64'd1) << item.arg_b[5:0];
    // 64-bit shifted operand plus addend, upper word kept for the carry form
    wide    = {32'd0, item.arg_a} << sh;
    low_sum = {1'b0, wide[31:0]} + {1'b0, item.arg_c};
    wide_hi = wide[63:32] + {31'd0, low_sum[32]};
    borrow  = ({1'b0, item.arg_b} + {32'd0, ci}) > {1'b0, item.arg_a};

    res.unsupported = 1'b0;
    case (sca_pkg::sca_op_t'(item.kind))
      sca_pkg::OP_ADD:        res.value = item.arg_a + item.arg_b;
      sca_pkg::OP_ADDC:       res.value = sum_ci[31:0];
      sca_pkg::OP_ADD_CO:     res.value = {31'd0, sum_ci[32]};
      sca_pkg::OP_SUB:        res.value = item.arg_a - item.arg_b;
      sca_pkg::OP_SUBB:       res.value = item.arg_a - item.arg_b - {31'd0, ci};
      sca_pkg::OP_SUB_BO:     res.value = {31'd0, borrow};
      sca_pkg::OP_MUL_LO:     res.value = prod;
      sca_pkg::OP_AND:        res.value = item.arg_a & item.arg_b;
      sca_pkg::OP_ANDN:       res.value = item.arg_a & ~item.arg_b;
      sca_pkg::OP_OR:         res.value = item.arg_a | item.arg_b;
      sca_pkg::OP_ORN:        res.value = item.arg_a | ~item.arg_b;
      sca_pkg::OP_XOR:        res.value = item.arg_a ^ item.arg_b;
      sca_pkg::OP_NOT:        res.value = ~item.arg_a;
      sca_pkg::OP_SHL:        res.value = shl;
      sca_pkg::OP_LSR:        res.value = item.arg_a >> sh;
      sca_pkg::OP_ASR:        res.value = $unsigned($signed(item.arg_a) >>> sh);
      sca_pkg::OP_MASK32:     res.value = mask32;
      sca_pkg::OP_MASK64_LO:  res.value = mask64[31:0];
      sca_pkg::OP_MASK64_HI:  res.value = mask64[63:32];
      sca_pkg::OP_ADD3:       res.value = item.arg_a + item.arg_b + item.arg_c;
      sca_pkg::OP_SHL_ADD:    res.value = low_sum[31:0];
      sca_pkg::OP_SHL_ADD_CO: res.value = wide_hi;
      sca_pkg::OP_ADD_SHL:    res.value = (item.arg_a + item.arg_b) << item.arg_c[4:0];
      sca_pkg::OP_XOR_ADD:    res.value = (item.arg_a ^ item.arg_b) + item.arg_c;
      sca_pkg::OP_SHL_OR:     res.value = shl | item.arg_c;
      default: begin
        res.value       = 32'd0;
        res.unsupported = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/scalar_constant_alu.sv @@
// ----------------------------------------------------------------------------
// scalar_constant_alu
// 32-bit scalar alu with 25 operations on three operands
// ----------------------------------------------------------------------------
// Each input transfer carries an operation code on s_axis_tuser and three
// 32-bit operands on s_axis_tdata; each yields exactly one output transfer
// with the 32-bit result on m_axis_tdata and the unsupported-code flag on
// m_axis_tuser (codes 25..31 give zero and the flag). The block takes one
// transfer per clock unless a stalled output has filled both registers. An
// accepted transfer is held in the input register; its result is loaded
// into the result register and offered on m_axis from there, with the whole
// operation (the 32x32 low multiply being the longest path) computed between
// the two registers. The input side keeps taking transfers while a finished
// result waits on a stalled output, until both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_constant_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // arg_a [31:0], arg_b [63:32], arg_c [95:64]
  input  wire logic [4:0]  s_axis_tuser,   // kind [4:0]
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // value [31:0]
  output      logic        m_axis_tuser    // unsupported [0]
);

  // input register stage
  logic                 in_valid;
  sca_pkg::sca_item_t   in_item;
  // result register stage
  logic                 out_valid;
  sca_pkg::sca_result_t out_res;
  sca_pkg::sca_result_t alu_res;
  logic                 out_load;

  // the result register loads a held item when it is empty or being drained
  assign out_load      = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.kind  <= s_axis_tuser;
      in_item.arg_a <= s_axis_tdata[31:0];
      in_item.arg_b <= s_axis_tdata[63:32];
      in_item.arg_c <= s_axis_tdata[95:64];
    end
    if (out_load) begin
      out_res <= alu_res;
    end
  end

  sca_alu u_alu (
    .item (in_item),
    .res  (alu_res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.value;
  assign m_axis_tuser  = out_res.unsupported;

endmodule

`default_nettype wire

@@ src/sca_checker.sv @@
// ----------------------------------------------------------------------------
// sca_checker
// port-level checks for the scalar constant alu
// ----------------------------------------------------------------------------
`default_nettype none

module sca_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // an unsupported code always carries a zero value
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("unsupported result with nonzero value");

  // with no result pending the input side must be open
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind scalar_constant_alu sca_checker u_sca_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
